### rtl/coag_pkg.sv
// ----------------------------------------------------------------------------
// coag_pkg
// Types and codes shared by the operand address generator modules.
// ----------------------------------------------------------------------------
package coag_pkg;

	// request action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DATA  = 1'b1;

	// addressing mode codes
	localparam logic [3:0] MODE_IMM  = 4'd0;
	localparam logic [3:0] MODE_ZP   = 4'd1;
	localparam logic [3:0] MODE_ZPX  = 4'd2;
	localparam logic [3:0] MODE_ZPY  = 4'd3;
	localparam logic [3:0] MODE_ABS  = 4'd4;
	localparam logic [3:0] MODE_ABSX = 4'd5;
	localparam logic [3:0] MODE_ABSY = 4'd6;
	localparam logic [3:0] MODE_INDX = 4'd7;
	localparam logic [3:0] MODE_INDY = 4'd8;

	// high byte of an address
	localparam logic [15:0] PAGE_MASK = 16'hFF00;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_OP1   = 3'd1,
		PH_OP2   = 3'd2,
		PH_PTRLO = 3'd3,
		PH_PTRHI = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_DONE   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  mode;
		logic [15:0] pc;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  ptr;
		logic [7:0]  low;
	} state_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] bus_address;
		logic [15:0] effective_address;
		logic        page_crossed;
		logic [15:0] next_pc;
	} result_t;

endpackage

### rtl/coag_step.sv
// ----------------------------------------------------------------------------
// coag_step
// Next state and result for one request, given the held sequencer state.
// ----------------------------------------------------------------------------
module coag_step (
	input  coag_pkg::state_t  st,
	input  logic              action,
	input  logic [3:0]        mode,
	input  logic [15:0]       program_counter,
	input  logic [7:0]        index_x,
	input  logic [7:0]        index_y,
	input  logic [7:0]        read_data,
	output coag_pkg::state_t  st_next,
	output coag_pkg::result_t res
);

	logic [15:0] pc1;
	logic [15:0] pc2;
	logic [15:0] base;
	logic [7:0]  idx;
	logic [15:0] idx_sum;
	logic        idx_cross;
	logic [7:0]  zp_x;
	logic [7:0]  zp_y;
	logic [7:0]  ptr_inc;

	// shared adders
	assign pc1       = st.pc + 16'd1;
	assign pc2       = st.pc + 16'd2;
	assign base      = {read_data, st.low};
	assign idx       = (st.mode == coag_pkg::MODE_ABSX) ? st.x : st.y;
	assign idx_sum   = base + {8'h00, idx};
	assign idx_cross = (base & coag_pkg::PAGE_MASK) != (idx_sum & coag_pkg::PAGE_MASK);
	assign zp_x      = read_data + st.x;
	assign zp_y      = read_data + st.y;
	assign ptr_inc   = st.ptr + 8'd1;

	// sequencer step
	always_comb begin
		st_next = st;
		res     = '0;
		res.kind = coag_pkg::KIND_REJECT;
		if (action == coag_pkg::ACT_START) begin
			if (st.phase == coag_pkg::PH_IDLE && mode <= coag_pkg::MODE_INDY) begin
				st_next.mode = mode;
				st_next.pc   = program_counter;
				st_next.x    = index_x;
				st_next.y    = index_y;
				if (mode == coag_pkg::MODE_IMM) begin
					res.kind              = coag_pkg::KIND_DONE;
					res.effective_address = program_counter;
					res.next_pc           = program_counter + 16'd1;
				end else begin
					st_next.phase   = coag_pkg::PH_OP1;
					res.kind        = coag_pkg::KIND_READ;
					res.bus_address = program_counter;
				end
			end
		end else begin
			unique case (st.phase)
				coag_pkg::PH_IDLE: begin
					res.kind = coag_pkg::KIND_REJECT;
				end
				coag_pkg::PH_OP1: begin
					case (st.mode) inside
						coag_pkg::MODE_ZP: begin
							st_next.phase         = coag_pkg::PH_IDLE;
							res.kind              = coag_pkg::KIND_DONE;
							res.effective_address = {8'h00, read_data};
							res.next_pc           = pc1;
						end
						coag_pkg::MODE_ZPX: begin
							st_next.phase         = coag_pkg::PH_IDLE;
							res.kind              = coag_pkg::KIND_DONE;
							res.effective_address = {8'h00, zp_x};
							res.next_pc           = pc1;
						end
						coag_pkg::MODE_ZPY: begin
							st_next.phase         = coag_pkg::PH_IDLE;
							res.kind              = coag_pkg::KIND_DONE;
							res.effective_address = {8'h00, zp_y};
							res.next_pc           = pc1;
						end
						coag_pkg::MODE_ABS, coag_pkg::MODE_ABSX, coag_pkg::MODE_ABSY: begin
							st_next.low     = read_data;
							st_next.phase   = coag_pkg::PH_OP2;
							res.kind        = coag_pkg::KIND_READ;
							res.bus_address = pc1;
						end
						coag_pkg::MODE_INDX: begin
							st_next.ptr     = zp_x;
							st_next.phase   = coag_pkg::PH_PTRLO;
							res.kind        = coag_pkg::KIND_READ;
							res.bus_address = {8'h00, zp_x};
						end
						default: begin
							st_next.ptr     = read_data;
							st_next.phase   = coag_pkg::PH_PTRLO;
							res.kind        = coag_pkg::KIND_READ;
							res.bus_address = {8'h00, read_data};
						end
					endcase
				end
				coag_pkg::PH_OP2: begin
					st_next.phase = coag_pkg::PH_IDLE;
					res.kind      = coag_pkg::KIND_DONE;
					res.next_pc   = pc2;
					if (st.mode == coag_pkg::MODE_ABSX || st.mode == coag_pkg::MODE_ABSY) begin
						res.effective_address = idx_sum;
						res.page_crossed      = idx_cross;
					end else begin
						res.effective_address = base;
					end
				end
				coag_pkg::PH_PTRLO: begin
					st_next.low     = read_data;
					st_next.phase   = coag_pkg::PH_PTRHI;
					res.kind        = coag_pkg::KIND_READ;
					res.bus_address = {8'h00, ptr_inc};
				end
				coag_pkg::PH_PTRHI: begin
					st_next.phase = coag_pkg::PH_IDLE;
					res.kind      = coag_pkg::KIND_DONE;
					res.next_pc   = pc1;
					if (st.mode == coag_pkg::MODE_INDY) begin
						res.effective_address = idx_sum;
						res.page_crossed      = idx_cross;
					end else begin
						res.effective_address = base;
					end
				end
				default: begin
					res.kind = coag_pkg::KIND_REJECT;
				end
			endcase
		end
	end

endmodule

### rtl/cpu_operand_address_generator_top.sv
// Latency: a result is shown in the cycle after its request is accepted.
// Throughput: one request per cycle while out_ready is high; the single
// output register sets the rate, and a new request is taken in the cycle
// the held result is taken. Reset (arst_n low, asynchronous) returns the
// sequencer to idle, clears all held operands, empties the output register.
// ----------------------------------------------------------------------------
// cpu_operand_address_generator_top
// Operand address generator for the nine 8-bit processor addressing modes.
// ----------------------------------------------------------------------------
module cpu_operand_address_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [3:0]  mode,
	input  logic [15:0] program_counter,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [7:0]  read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] bus_address,
	output logic [15:0] effective_address,
	output logic        page_crossed,
	output logic [15:0] next_pc
);

	coag_pkg::state_t  state_q;
	coag_pkg::state_t  st_next;
	coag_pkg::result_t res;
	coag_pkg::result_t res_q;
	logic              out_valid_q;
	logic              accept;

	// request handshake
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	coag_step u_step (
		.st              (state_q),
		.action          (action),
		.mode            (mode),
		.program_counter (program_counter),
		.index_x         (index_x),
		.index_y         (index_y),
		.read_data       (read_data),
		.st_next         (st_next),
		.res             (res)
	);

	// sequencer state, all zero is idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= st_next;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign kind              = res_q.kind;
	assign bus_address       = res_q.bus_address;
	assign effective_address = res_q.effective_address;
	assign page_crossed      = res_q.page_crossed;
	assign next_pc           = res_q.next_pc;

`ifndef SYNTHESIS
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted request produced no result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.kind == coag_pkg::KIND_DONE |=> state_q.phase == coag_pkg::PH_IDLE)
		else $error("sequencer not idle after done");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.kind == coag_pkg::KIND_REJECT |=> state_q == $past(state_q))
		else $error("rejected request changed state");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.kind == coag_pkg::KIND_READ |=> state_q.phase != coag_pkg::PH_IDLE)
		else $error("read request left sequencer idle");

	a_cross_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.page_crossed |-> res_q.kind == coag_pkg::KIND_DONE)
		else $error("page cross flagged outside done result");
`endif

endmodule
